// ===== rtl/nbca_pkg.sv =====
package nbca_pkg;

  // geometry and configuration
  localparam int unsigned NBCA_MAX_WIDTH   = 1024;
  localparam int unsigned COL_W            = 11;
  localparam int unsigned ROW_W            = 13;
  localparam int unsigned CFG_W            = 13;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned FRAME_WIDTH_RST  = 1024;
  localparam int unsigned FRAME_HEIGHT_RST = 1024;

  // flags: bit 0 max set, bit 1 min set, bit 2 current set
  localparam int unsigned FLAG_W     = 3;
  localparam int unsigned MEM_W      = 2 * FLAG_W;
  localparam int unsigned WIN_TAPS   = 9;
  localparam int unsigned CENTER_TAP = 4;
  localparam int unsigned WIN_W      = WIN_TAPS * FLAG_W;

  // contribution arithmetic
  localparam int unsigned NCNT_W    = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned COLOR_MAX = 255;
  localparam int unsigned COLOR_CUR = 127;

  // divider: quotient bits resolved per stage
  localparam int unsigned DIV_STEP   = 2;
  localparam int unsigned DIV_STAGES = COLOR_W / DIV_STEP;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic in_max_set;
    logic in_min_set;
    logic in_current_set;
  } in_beat_t;

  typedef struct packed {
    logic               has_color;
    logic [COLOR_W-1:0] border_color;
    logic               frame_last;
  } out_beat_t;

  typedef struct packed {
    logic             frame_last;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
  } div_req_t;

endpackage

// ===== rtl/nbca_line_mem.sv =====
module nbca_line_mem import nbca_pkg::*; #(
  parameter int unsigned DEPTH = NBCA_MAX_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [MEM_W-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [MEM_W-1:0]         wr_data_i
);

  // two stored rows per column: {row before previous, previous row}
  logic [MEM_W-1:0] mem_q [DEPTH];
  logic [MEM_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/nbca_divider.sv =====
module nbca_divider import nbca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  div_req_t  req_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_beat_t res_o
);

  logic [DIV_STAGES-1:0] valid_q;
  logic [SUM_W-1:0]      rem_q  [DIV_STAGES];
  logic [SUM_W-1:0]      rem_d  [DIV_STAGES];
  logic [CNT_W-1:0]      cnt_q  [DIV_STAGES];
  logic [CNT_W-1:0]      cnt_d  [DIV_STAGES];
  logic [COLOR_W-1:0]    quo_q  [DIV_STAGES];
  logic [COLOR_W-1:0]    quo_d  [DIV_STAGES];
  logic [DIV_STAGES-1:0] last_q;
  logic [DIV_STAGES-1:0] last_d;
  logic [DIV_STAGES-1:0] valid_d;
  logic [DIV_STAGES:0]   rdy;

  // stage ready chain, bubbles collapse
  always_comb begin
    rdy[DIV_STAGES] = res_ready_i;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !valid_q[s] || rdy[s+1];
    end
  end

  assign req_ready_o = rdy[0];

  // restoring division, DIV_STEP quotient bits per stage
  always_comb begin
    logic [SUM_W-1:0]   rem;
    logic [SUM_W-1:0]   trial;
    logic [COLOR_W-1:0] quo;
    logic [CNT_W-1:0]   cnt;
    int                 pos;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem        = req_i.sum;
        cnt        = req_i.cnt;
        quo        = '0;
        last_d[s]  = req_i.frame_last;
        valid_d[s] = req_valid_i;
      end else begin
        rem        = rem_q[s-1];
        cnt        = cnt_q[s-1];
        quo        = quo_q[s-1];
        last_d[s]  = last_q[s-1];
        valid_d[s] = valid_q[s-1];
      end
      for (int b = 0; b < DIV_STEP; b++) begin
        pos   = COLOR_W - 1 - s * DIV_STEP - b;
        trial = SUM_W'(cnt) << pos;
        if (rem >= trial) begin
          rem      = rem - trial;
          quo[pos] = 1'b1;
        end
      end
      rem_d[s] = rem;
      cnt_d[s] = cnt;
      quo_d[s] = quo;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        if (rdy[s]) begin
          valid_q[s] <= valid_d[s];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rdy[s]) begin
        rem_q[s]  <= rem_d[s];
        cnt_q[s]  <= cnt_d[s];
        quo_q[s]  <= quo_d[s];
        last_q[s] <= last_d[s];
      end
    end
  end

  // result beat, color forced to zero when nothing contributed
  always_comb begin
    res_o.has_color    = cnt_q[DIV_STAGES-1] != '0;
    res_o.border_color = res_o.has_color ? quo_q[DIV_STAGES-1] : '0;
    res_o.frame_last   = last_q[DIV_STAGES-1];
  end

  assign res_valid_o = valid_q[DIV_STAGES-1];

endmodule

// ===== rtl/neighbour_border_color_average.sv =====
// Streams one position of a (height+1) x (width+1) raster per beat, row by row, each
// beat carrying the max, min and current set flags of that pixel (flags on the padding
// row and column are ignored). Every set member gives its color (255, 0, 127) to each
// in-image 8-neighbour, and the result for pixel (r-1, c-1) is emitted for position
// (r, c) as the floor average of what it received, with has_color low and color 0 when
// nothing arrived; frame_last marks the final pixel. A new beat is taken on every clock
// when the output side keeps up; the line memory is read and written at most once per
// beat, and a result passes the three front stages a, b, c and the four-stage divider.
// Writing frame_width or frame_height restarts the frame and must only be done while
// no beat is in flight; the line memory needs no clearing after reset since rows
// above the image are masked.
module neighbour_border_color_average import nbca_pkg::*; #(
  parameter int unsigned MAX_WIDTH = NBCA_MAX_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_beat_t             in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_beat_t            out_beat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);

  function automatic logic [COL_W-1:0] clamp_width(logic [COL_W-1:0] raw);
    logic [COL_W-1:0] w;
    w = (raw == '0) ? COL_W'(1) : raw;
    if (32'(w) > 32'(MAX_WIDTH)) begin
      w = COL_W'(MAX_WIDTH);
    end
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(logic [ROW_W-1:0] raw);
    return (raw == '0) ? ROW_W'(1) : raw;
  endfunction

  typedef struct packed {
    logic [FLAG_W-1:0] cur;
    logic              acc;
    logic              use_a;
    logic              use_b;
    logic              first;
    logic              prod;
    logic              last;
    logic [AddrW-1:0]  addr;
  } stage_a_t;

  logic [COL_W-1:0] eff_w_q;
  logic [ROW_W-1:0] eff_h_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [WIN_W-1:0] win_q;
  logic [WIN_W-1:0] win_d;

  logic     a_valid_q;
  stage_a_t a_q;
  stage_a_t a_d;
  logic     b_valid_q;
  logic     b_last_q;
  logic     c_valid_q;
  div_req_t c_q;
  div_req_t c_d;

  logic             in_acc;
  logic             a_adv;
  logic             b_ready;
  logic             c_ready;
  logic             div_ready;
  logic [MEM_W-1:0] rd_data;
  logic [FLAG_W-1:0] above;
  logic [FLAG_W-1:0] above2;
  logic             wr_en;

  // handshake chain, bubbles collapse
  assign c_ready    = !c_valid_q || div_ready;
  assign b_ready    = !b_valid_q || c_ready;
  assign in_ready_o = !a_valid_q || b_ready;
  assign a_adv      = a_valid_q && b_ready;
  assign in_acc     = in_valid_i && in_ready_o;

  // position decode at accept
  always_comb begin
    a_d.acc   = col_q < eff_w_q;
    a_d.cur   = (a_d.acc && row_q < eff_h_q)
              ? {in_beat_i.in_current_set, in_beat_i.in_min_set, in_beat_i.in_max_set}
              : '0;
    a_d.use_a = row_q >= ROW_W'(1);
    a_d.use_b = row_q >= ROW_W'(2);
    a_d.first = col_q == '0;
    a_d.prod  = row_q != '0 && col_q != '0;
    a_d.last  = row_q == eff_h_q && col_q == eff_w_q;
    a_d.addr  = AddrW'(col_q);
  end

  // configuration and raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= clamp_width(COL_W'(FRAME_WIDTH_RST));
      eff_h_q <= clamp_height(ROW_W'(FRAME_HEIGHT_RST));
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH: begin
          eff_w_q <= clamp_width(cfg_data_i[COL_W-1:0]);
        end
        CFG_FRAME_HEIGHT: begin
          eff_h_q <= clamp_height(cfg_data_i[ROW_W-1:0]);
        end
        default: begin
        end
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (col_q == eff_w_q) begin
        col_q <= '0;
        row_q <= (row_q == eff_h_q) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // line memory: read at accept, write back when the beat leaves stage a
  nbca_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc && a_d.acc),
    .rd_addr_i (a_d.addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (a_q.addr),
    .wr_data_i ({above, a_q.cur})
  );

  // mask stored rows above the image
  always_comb begin
    above  = (a_q.acc && a_q.use_a) ? rd_data[FLAG_W-1:0] : '0;
    above2 = (a_q.acc && a_q.use_b) ? rd_data[MEM_W-1:FLAG_W] : '0;
    wr_en  = a_adv && a_q.acc;
    if (a_q.first) begin
      win_d = {a_q.cur, above, above2, {(WIN_W - FLAG_W * 3){1'b0}}};
    end else begin
      win_d = {a_q.cur, above, above2, win_q[WIN_W-1:FLAG_W*3]};
    end
  end

  // stage a valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= a_d;
    end
  end

  // 3x3 flag window, stage b
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      b_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      win_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        win_q <= win_d;
      end
      if (b_ready) begin
        b_valid_q <= a_adv && a_q.prod;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_last_q <= a_q.last;
    end
  end

  // count and sum of the eight neighbours
  always_comb begin
    logic [NCNT_W-1:0] n_max;
    logic [NCNT_W-1:0] n_min;
    logic [NCNT_W-1:0] n_cur;
    n_max = '0;
    n_min = '0;
    n_cur = '0;
    for (int p = 0; p < WIN_TAPS; p++) begin
      if (p != CENTER_TAP) begin
        n_max = n_max + NCNT_W'(win_q[p*FLAG_W]);
        n_min = n_min + NCNT_W'(win_q[p*FLAG_W+1]);
        n_cur = n_cur + NCNT_W'(win_q[p*FLAG_W+2]);
      end
    end
    c_d.frame_last = b_last_q;
    c_d.cnt        = CNT_W'(n_max) + CNT_W'(n_min) + CNT_W'(n_cur);
    c_d.sum        = SUM_W'(n_max) * SUM_W'(COLOR_MAX) + SUM_W'(n_cur) * SUM_W'(COLOR_CUR);
  end

  // stage c
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_q <= c_d;
    end
  end

  nbca_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (c_valid_q),
    .req_ready_o (div_ready),
    .req_i       (c_q),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (out_beat_o)
  );

`ifndef SYNTHESIS
  // read and write back never hit the same column in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && in_acc && a_d.acc) |-> (a_q.addr != a_d.addr))
    else $error("line memory read and write collide");

  // column position stays within the padded row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= eff_w_q)
    else $error("column position beyond padded width");

  // row position stays within the padded frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= eff_h_q)
    else $error("row position beyond padded height");
`endif

endmodule

// ===== verif/tb_neighbour_border_color_average.sv =====
`timescale 1ns / 1ps

module tb_neighbour_border_color_average;
  import nbca_pkg::*;

  localparam int unsigned FLUSH_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned MIN_SET_COLOR  = 0;

  // flag bit positions inside a window tap
  localparam int unsigned FLAG_MAX_BIT = 0;
  localparam int unsigned FLAG_MIN_BIT = 1;
  localparam int unsigned FLAG_CUR_BIT = 2;

  localparam in_beat_t FLAGS_NONE = 3'b000;
  localparam in_beat_t FLAGS_MAX  = 3'b100;
  localparam in_beat_t FLAGS_MIN  = 3'b010;
  localparam in_beat_t FLAGS_CUR  = 3'b001;
  localparam in_beat_t FLAGS_ALL  = 3'b111;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_beat_t             in_beat_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_beat_t            out_beat_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  // shadow state of the color predictor
  int unsigned          shadow_width  = FRAME_WIDTH_RST;
  int unsigned          shadow_height = FRAME_HEIGHT_RST;
  logic [FLAG_W-1:0]    prev_row  [NBCA_MAX_WIDTH] = '{default: '0};
  logic [FLAG_W-1:0]    prev_row2 [NBCA_MAX_WIDTH] = '{default: '0};
  logic [WIN_W-1:0]     flag_win  = '0;
  int unsigned          col_pos   = 0;
  int unsigned          row_pos   = 0;

  out_beat_t            expected_colors [$];
  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count    = 0;
  int unsigned          send_idle_pct  = 27;
  int unsigned          recv_idle_pct  = 57;
  int unsigned          hold_requests  = 0;
  int unsigned          hold_served    = 0;
  int unsigned          hold_left      = 0;

  neighbour_border_color_average u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned eff_frame_width();
    int unsigned w;
    w = shadow_width;
    if (w == 0) w = 1;
    if (w > NBCA_MAX_WIDTH) w = NBCA_MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_frame_height();
    int unsigned h;
    h = shadow_height;
    if (h == 0) h = 1;
    return h;
  endfunction

  function automatic int unsigned frame_positions();
    return (eff_frame_width() + 1) * (eff_frame_height() + 1);
  endfunction

  // advance the shadow raster by one beat and queue the color it produces
  task automatic predict_border_color(input in_beat_t beat);
    int unsigned        w, h, c, r, k, j, cnt, sum;
    logic [FLAG_W-1:0]  cur, above, above2, f;
    logic [3*FLAG_W-1:0] column;
    out_beat_t          res;
    w = eff_frame_width();
    h = eff_frame_height();
    c = (col_pos > w) ? w : col_pos;
    r = (row_pos > h) ? h : row_pos;
    cur    = '0;
    above  = '0;
    above2 = '0;
    // padding flags are dropped
    if (r < h && c < w) cur = {beat.in_current_set, beat.in_min_set, beat.in_max_set};
    // rows above the image read as empty
    if (c < w) begin
      if (r >= 1) above = prev_row[c];
      if (r >= 2) above2 = prev_row2[c];
      prev_row2[c] = above;
      prev_row[c]  = cur;
    end
    column = {cur, above, above2};
    if (c == 0) begin
      flag_win = {column, {(WIN_W - 3*FLAG_W){1'b0}}};
    end else begin
      flag_win = {column, flag_win[WIN_W-1:3*FLAG_W]};
    end
    // sum contributions of the eight neighbours
    if (r >= 1 && c >= 1) begin
      cnt = 0;
      sum = 0;
      for (k = 0; k < 3; k++) begin
        for (j = 0; j < 3; j++) begin
          if (!(k == 1 && j == 1)) begin
            f = flag_win[(k*3 + j)*FLAG_W +: FLAG_W];
            if (f[FLAG_MAX_BIT]) begin cnt++; sum += COLOR_MAX; end
            if (f[FLAG_MIN_BIT]) begin cnt++; sum += MIN_SET_COLOR; end
            if (f[FLAG_CUR_BIT]) begin cnt++; sum += COLOR_CUR; end
          end
        end
      end
      res.has_color    = (cnt != 0);
      res.border_color = (cnt != 0) ? COLOR_W'(sum / cnt) : '0;
      res.frame_last   = (r == h && c == w);
      expected_colors.push_back(res);
    end
    c++;
    if (c > w) begin
      c = 0;
      r++;
      if (r > h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // result checker and receiver ready
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: %p", out_beat_o));
        end else begin
          want = expected_colors.pop_front();
          if (out_beat_o.has_color !== want.has_color)
            report_mismatch($sformatf("has_color got %b exp %b",
                                      out_beat_o.has_color, want.has_color));
          if (out_beat_o.border_color !== want.border_color)
            report_mismatch($sformatf("border_color got %0d exp %0d",
                                      out_beat_o.border_color, want.border_color));
          if (out_beat_o.frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last got %b exp %b",
                                      out_beat_o.frame_last, want.frame_last));
        end
      end
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one beat, with random gaps ahead of it, and wait for acceptance
  task automatic send_pixel(input in_beat_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_border_color(beat);
  endtask

  function automatic in_beat_t random_flags(input int unsigned density);
    in_beat_t b;
    b.in_max_set     = ($urandom_range(99) < density);
    b.in_min_set     = ($urandom_range(99) < density);
    b.in_current_set = ($urandom_range(99) < density);
    return b;
  endfunction

  task automatic send_random_pixels(input int unsigned count, input int unsigned density);
    int unsigned i;
    for (i = 0; i < count; i++) send_pixel(random_flags(density));
  endtask

  // let every expected color arrive and the pipeline empty out
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (FLUSH_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    if (idx == CFG_FRAME_WIDTH) shadow_width = 32'(value[COL_W-1:0]);
    else shadow_height = 32'(value[ROW_W-1:0]);
    // any write restarts the frame
    col_pos  = 0;
    row_pos  = 0;
    flag_win = '0;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_for_idle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // reset geometry: 1024 wide, so the first row gives no results
  task automatic test_reset_geometry();
    send_random_pixels(12, 50);
  endtask

  task automatic test_directed_patterns();
    // zero registers act as one pixel, which has no neighbours
    configure_frame(0, 0);
    repeat (4) send_pixel(FLAGS_ALL);
    // a single source pixel per set, padding flags set, frames back to back
    configure_frame(2, 1);
    send_pixel(FLAGS_MAX);
    send_pixel(FLAGS_NONE);
    repeat (4) send_pixel(FLAGS_ALL);
    send_pixel(FLAGS_MIN);
    send_pixel(FLAGS_NONE);
    repeat (4) send_pixel(FLAGS_ALL);
    send_pixel(FLAGS_CUR);
    send_pixel(FLAGS_NONE);
    repeat (4) send_pixel(FLAGS_ALL);
    // full neighbourhood: the center pixel gets all 24 contributions
    configure_frame(3, 3);
    repeat (16) send_pixel(FLAGS_ALL);
  endtask

  task automatic test_extreme_sizes();
    // width beyond the line memory is clamped, whole line memory in use
    configure_frame(13'h07FF, 1);
    send_random_pixels(NBCA_MAX_WIDTH + 4, 50);
    // tall frame, one column
    configure_frame(1, 12);
    send_random_pixels(frame_positions(), 30);
  endtask

  // mostly whole frames, some cut short, some run twice
  task automatic test_random_frames(input int unsigned target);
    int unsigned sent, w, h, total, count, density;
    logic [CFG_W-1:0] wdata;
    sent = 0;
    while (sent < target) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      wdata = CFG_W'(w);
      // upper data bits do not belong to the width register
      if ($urandom_range(3) == 0) wdata[CFG_W-1:COL_W] = (CFG_W-COL_W)'($urandom_range(3));
      wait_for_idle();
      write_reg(CFG_FRAME_WIDTH, wdata);
      write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
      total = frame_positions();
      case ($urandom_range(9))
        0, 1:    count = $urandom_range(1, total - 1);
        2:       count = 2 * total;
        default: count = total;
      endcase
      density = ($urandom_range(4) == 0) ? $urandom_range(0, 100) : $urandom_range(10, 60);
      send_random_pixels(count, density);
      sent += count;
    end
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_back_pressure();
    int unsigned i;
    configure_frame(4, 3);
    for (i = 0; i < 3 * frame_positions(); i++) begin
      if (i == 10) hold_requests++;
      send_pixel(random_flags(40));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 57;
    test_reset_geometry();
    test_directed_patterns();
    test_extreme_sizes();
    test_random_frames(16);

    send_idle_pct = 57;
    recv_idle_pct = 27;
    test_random_frames(16);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(16);
    test_back_pressure();

    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nbca_pkg.sv
rtl/nbca_line_mem.sv
rtl/nbca_divider.sv
rtl/neighbour_border_color_average.sv
verif/tb_neighbour_border_color_average.sv
